### sv/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Types, mode codes and the sprite table of the segment status animator.
// ----------------------------------------------------------------------------
package ssa_pkg;

  // operation codes of an input beat
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MODE = 1'b1;

  localparam int unsigned NUM_SPRITES = 37;
  localparam logic [4:0]  NUM_MODES   = 5'd19;
  localparam int unsigned SPRITE_W    = 6;

  typedef enum logic [4:0] {
    MODE_OFF          = 5'd0,
    MODE_IDLE         = 5'd1,
    MODE_RUN          = 5'd2,
    MODE_RUN_WDT      = 5'd3,
    MODE_BAT_CRIT     = 5'd4,
    MODE_BAT_LOW      = 5'd5,
    MODE_BAT_MED      = 5'd6,
    MODE_BAT_HIGH     = 5'd7,
    MODE_CHG_LOW      = 5'd8,
    MODE_CHG_MED      = 5'd9,
    MODE_CHG_HIGH     = 5'd10,
    MODE_CHG_COMPLETE = 5'd11,
    MODE_WDT_EXPIRED  = 5'd12,
    MODE_ERR1         = 5'd13,
    MODE_ERR2         = 5'd14,
    MODE_ERR3         = 5'd15,
    MODE_ERR4         = 5'd16,
    MODE_ERR5         = 5'd17,
    MODE_UNKNOWN      = 5'd18
  } mode_t;

  typedef logic [SPRITE_W-1:0] sprite_idx_t;

  // sprite indices
  localparam sprite_idx_t SP_OFF   = 6'd0;
  localparam sprite_idx_t SP_BAT1  = 6'd2;
  localparam sprite_idx_t SP_BAT2  = 6'd3;
  localparam sprite_idx_t SP_BAT3  = 6'd4;
  localparam sprite_idx_t SP_IDLE0 = 6'd5;
  localparam sprite_idx_t SP_IDLE1 = 6'd6;
  localparam sprite_idx_t SP_RUN0  = 6'd7;
  localparam sprite_idx_t SP_RWD0  = 6'd13;
  localparam sprite_idx_t SP_ERR   = 6'd19;
  localparam sprite_idx_t SP_DIG1  = 6'd22;
  localparam sprite_idx_t SP_LET_C = 6'd31;
  localparam sprite_idx_t SP_LET_L = 6'd32;
  localparam sprite_idx_t SP_LET_B = 6'd33;
  localparam sprite_idx_t SP_WDT1  = 6'd34;
  localparam sprite_idx_t SP_WDT2  = 6'd35;
  localparam sprite_idx_t SP_UNK   = 6'd36;

  typedef struct packed {
    logic       operation;
    logic [4:0] mode;
  } item_t;

  typedef struct packed {
    logic [7:0] segments;
    logic       drawn;
  } result_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] count;
    logic [7:0] seg;
  } anim_state_t;

  // segment patterns, bit0 A .. bit6 G, bit7 DP
  function automatic logic [7:0] sprite_rom(input sprite_idx_t idx);
    logic [7:0] pat;
    unique case (idx)
      6'd0:  pat = 8'h00;  6'd1:  pat = 8'h00;  6'd2:  pat = 8'h01;  6'd3:  pat = 8'h41;
      6'd4:  pat = 8'h49;  6'd5:  pat = 8'h00;  6'd6:  pat = 8'h80;  6'd7:  pat = 8'h08;
      6'd8:  pat = 8'h10;  6'd9:  pat = 8'h20;  6'd10: pat = 8'h01;  6'd11: pat = 8'h02;
      6'd12: pat = 8'h04;  6'd13: pat = 8'h88;  6'd14: pat = 8'h10;  6'd15: pat = 8'hA0;
      6'd16: pat = 8'h01;  6'd17: pat = 8'h82;  6'd18: pat = 8'h04;  6'd19: pat = 8'h4F;
      6'd20: pat = 8'h67;  6'd21: pat = 8'h3F;  6'd22: pat = 8'h30;  6'd23: pat = 8'h5B;
      6'd24: pat = 8'h79;  6'd25: pat = 8'h74;  6'd26: pat = 8'h6D;  6'd27: pat = 8'h6F;
      6'd28: pat = 8'h38;  6'd29: pat = 8'h7F;  6'd30: pat = 8'h7D;  6'd31: pat = 8'h0F;
      6'd32: pat = 8'h07;  6'd33: pat = 8'h67;  6'd34: pat = 8'h12;  6'd35: pat = 8'h24;
      6'd36: pat = 8'h5A;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

### sv/segment_status_animator.sv
// ----------------------------------------------------------------------------
// segment_status_animator
// Animation sequencer for an eight-segment status display (A..G plus DP).
// ----------------------------------------------------------------------------
// Each item beat is either a period tick or a mode request, and gives exactly
// one result beat with the segment drive and a drawn flag. Throughput is one
// beat per clock while result_ready stays high. The input register holds the
// beat, and the step logic loads the result register once it is free or being
// drained. The mode, tick counter and segment state update as the beat leaves
// the input register, so each beat sees the state left by the one before it.
// A requested mode above the last one, or equal to the current mode, leaves
// everything unchanged and reports drawn low. After reset the block is in the
// off mode with all segments dark.
// ----------------------------------------------------------------------------
module segment_status_animator (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ssa_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output ssa_pkg::result_t  result
);
  import ssa_pkg::*;

  // input register
  logic        s1_valid;
  item_t       s1_item;
  logic        advance;

  // animation state
  anim_state_t state;
  anim_state_t state_next;
  result_t     res_next;

  // the held beat moves on when the result register is free or being drained
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  // step logic between input and result registers
  ssa_step u_step (
    .cur  (state),
    .item (s1_item),
    .nxt  (state_next),
    .res  (res_next)
  );

  // state only moves with a beat, so stalls never disturb the animation
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode  <= MODE_OFF;
      state.count <= 8'd0;
      state.seg   <= 8'h00;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

  // run modes step through six frames only
  a_run_window: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_RUN || state.mode == MODE_RUN_WDT) |-> state.count <= 8'd5)
    else $error("run mode counter outside its window");

  // battery high rewinds to the second frame, never beyond the third
  a_bat_high_window: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_BAT_HIGH) |-> state.count <= 8'd8)
    else $error("battery high counter outside its window");

  // charge complete pins its counter
  a_chg_complete_count: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_CHG_COMPLETE) |-> state.count == 8'd0)
    else $error("charge complete counter not held at zero");

  // off mode keeps the display dark
  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_OFF) |-> state.seg == 8'h00)
    else $error("segments lit in off mode");

  // a result taken from the register reflects the state left by its beat
  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (result.segments == state.seg))
    else $error("result segments differ from display state");

endmodule

### sv/ssa_step.sv
// ----------------------------------------------------------------------------
// ssa_step
// One animation step: next mode, counter and segments for one input beat.
// ----------------------------------------------------------------------------
module ssa_step (
  input  ssa_pkg::anim_state_t cur,
  input  ssa_pkg::item_t       item,
  output ssa_pkg::anim_state_t nxt,
  output ssa_pkg::result_t     res
);
  import ssa_pkg::*;

  mode_t       m_sel;
  logic [7:0]  c_sel;
  logic [7:0]  seg_base;
  logic        run;
  sprite_idx_t idx;
  logic        hold;
  logic [7:0]  cnt_out;
  logic [4:0]  err_ofs;

  // operation decode
  always_comb begin
    m_sel    = cur.mode;
    c_sel    = cur.count;
    seg_base = cur.seg;
    run      = 1'b0;
    if (item.operation == OP_TICK) begin
      c_sel = cur.count + 8'd1;
      run   = 1'b1;
    end else if ((item.mode < NUM_MODES) && (item.mode != cur.mode)) begin
      m_sel    = mode_t'(item.mode);
      c_sel    = 8'd0;
      seg_base = 8'h00;
      run      = 1'b1;
    end
  end

  assign err_ofs = m_sel - MODE_ERR1;

  // per-mode counter windows
  always_comb begin
    idx     = SP_OFF;
    hold    = 1'b0;
    cnt_out = c_sel;
    unique case (m_sel)
      MODE_OFF: idx = SP_OFF;
      MODE_IDLE: begin
        if (c_sel < 8'd5)       idx = SP_IDLE1;
        else if (c_sel < 8'd10) idx = SP_IDLE0;
        else begin hold = 1'b1; cnt_out = 8'd0; end
      end
      MODE_RUN, MODE_RUN_WDT: begin
        if (c_sel > 8'd5) cnt_out = 8'd0;
        idx = ((m_sel == MODE_RUN) ? SP_RUN0 : SP_RWD0) + {3'b000, cnt_out[2:0]};
      end
      MODE_BAT_CRIT: begin
        if (c_sel < 8'd3)       idx = SP_LET_C;
        else if (c_sel < 8'd6)  idx = SP_LET_L;
        else if (c_sel < 8'd9)  idx = SP_LET_B;
        else if (c_sel < 8'd12) idx = SP_OFF;
        else begin hold = 1'b1; cnt_out = 8'd0; end
      end
      MODE_BAT_LOW: idx = c_sel[0] ? SP_OFF : SP_BAT1;
      MODE_BAT_MED: begin
        if (c_sel < 8'd3)      idx = SP_BAT1;
        else if (c_sel < 8'd6) idx = SP_BAT2;
        else begin hold = 1'b1; cnt_out = 8'd0; end
      end
      MODE_BAT_HIGH: begin
        if (c_sel < 8'd3)      idx = SP_BAT1;
        else if (c_sel < 8'd6) idx = SP_BAT2;
        else if (c_sel < 8'd9) idx = SP_BAT3;
        else begin hold = 1'b1; cnt_out = 8'd3; end
      end
      MODE_CHG_LOW: begin
        if (c_sel < 8'd3)       idx = SP_BAT1;
        else if (c_sel < 8'd6)  idx = SP_BAT2;
        else if (c_sel < 8'd9)  idx = SP_BAT3;
        else if (c_sel < 8'd12) idx = SP_OFF;
        else begin hold = 1'b1; cnt_out = 8'd0; end
      end
      MODE_CHG_MED: begin
        if (c_sel < 8'd3)      idx = SP_BAT2;
        else if (c_sel < 8'd6) idx = SP_BAT3;
        else if (c_sel < 8'd9) idx = SP_BAT1;
        else begin hold = 1'b1; cnt_out = 8'd0; end
      end
      MODE_CHG_HIGH: begin
        if (c_sel < 8'd3)      idx = SP_BAT3;
        else if (c_sel < 8'd6) idx = SP_BAT2;
        else begin hold = 1'b1; cnt_out = 8'd0; end
      end
      MODE_CHG_COMPLETE: begin
        idx     = SP_BAT3;
        cnt_out = 8'd0;
      end
      MODE_WDT_EXPIRED: begin
        if (c_sel < 8'd4)      idx = SP_WDT1;
        else if (c_sel < 8'd7) idx = SP_WDT2;
        else begin hold = 1'b1; cnt_out = 8'd0; end
      end
      MODE_ERR1, MODE_ERR2, MODE_ERR3, MODE_ERR4, MODE_ERR5: begin
        if (c_sel < 8'd5)       idx = SP_ERR;
        else if (c_sel < 8'd10) idx = SP_DIG1 + {1'b0, err_ofs};
        else begin hold = 1'b1; cnt_out = 8'd0; end
      end
      MODE_UNKNOWN: begin
        if (c_sel < 8'd3)       idx = SP_UNK;
        else if (c_sel < 8'd10) idx = SP_OFF;
        else begin hold = 1'b1; cnt_out = 8'd0; end
      end
      default: hold = 1'b1;
    endcase
  end

  always_comb begin
    nxt.mode  = m_sel;
    nxt.count = run ? cnt_out : cur.count;
    nxt.seg   = (run && !hold) ? sprite_rom(idx) : seg_base;
    res.segments = nxt.seg;
    res.drawn    = run && !hold;
  end

endmodule
